// ===== rtl/dsh_pkg.sv =====
// ----------------------------------------------------------------------------
// dsh_pkg: shared types, constants and microcode for the steering unit
// Holds the control word layout, the step program, the arctangent table and
// the fixed widths of the heading, angle and speed datapath.
// ----------------------------------------------------------------------------
package dsh_pkg;

  // field widths
  localparam int SPD_W      = 16;   // heading and wheel speed words, Q8.8
  localparam int CFG_W      = 15;   // widest configuration register
  localparam int CFG_IDX_W  = 2;
  localparam int ANGLE_W    = 15;   // thresholds and |angle|, Q2.13
  localparam int SPEED_W    = 14;   // max speed and base speed
  localparam int MODE_W     = 2;

  // internal datapath widths
  localparam int XY_W       = 28;   // cordic x / y, heading scaled by 256
  localparam int Z_W        = 34;   // angle accumulator, 2^-32 turn units
  localparam int AP_W       = Z_W + 17;
  localparam int ANG_RAW_W  = AP_W - 32;
  localparam int SQ_W       = 32;   // x^2 + y^2 and root remainder
  localparam int SPD_EXT_W  = 18;   // speed arithmetic before saturation
  localparam int TAB_IDX_W  = 5;
  localparam int TAB_LEN    = 24;

  // iteration counts
  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = SPEED_W;

  // constants
  localparam int PI_Q13     = 25736;
  localparam int RAD_SCALE  = 51472;
  localparam int SPD_LIMIT  = 32767;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HARD_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELAX_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CAP = 2'd3;

  // turn modes
  localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOFT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HARD     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD     = 2'd3;

  typedef struct packed {
    logic [ANGLE_W-1:0] hard_thr;
    logic [ANGLE_W-1:0] relax_thr;
    logic [ANGLE_W-1:0] straight;
    logic [SPEED_W-1:0] speed_cap;
  } cfg_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PRE,
    OP_SQ,
    OP_ITER,
    OP_AMUL,
    OP_AFIN,
    OP_MODE,
    OP_PROD,
    OP_DIV,
    OP_EMIT
  } op_t;

  // sequencer conditions
  typedef enum logic [2:0] {
    C_NEXT,         // go to pc + 1
    C_GOTO,         // go to target
    C_IF_NOT_SOFT,  // go to target when mode is not soft, else pc + 1
    C_HOLD_IN,      // stay until an input word arrives, then target
    C_HOLD_LOOP,    // stay until the loop count is done, then target
    C_HOLD_OUT      // stay until the output register is free, then target
  } cond_t;

  typedef enum logic {
    LIM_MAIN,
    LIM_DIV
  } lim_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t P_WAIT = 4'd0;
  localparam pc_t P_PRE  = 4'd1;
  localparam pc_t P_SQ   = 4'd2;
  localparam pc_t P_LOOP = 4'd3;
  localparam pc_t P_AMUL = 4'd4;
  localparam pc_t P_AFIN = 4'd5;
  localparam pc_t P_MODE = 4'd6;
  localparam pc_t P_PROD = 4'd7;
  localparam pc_t P_DIV  = 4'd8;
  localparam pc_t P_EMIT = 4'd9;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond;
    lim_t  lim;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    op_t                  op;
    logic [TAB_IDX_W-1:0] iter;
  } ctrl_t;

  typedef struct packed {
    logic is_soft;
    logic out_free;
  } stat_t;

  // step program
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{accept: 1'b0, op: OP_NOP, cond: C_GOTO, lim: LIM_MAIN, target: P_WAIT};
    case (pc)
      P_WAIT: w = '{1'b1, OP_LOAD, C_HOLD_IN,     LIM_MAIN, P_PRE};
      P_PRE:  w = '{1'b0, OP_PRE,  C_NEXT,        LIM_MAIN, P_WAIT};
      P_SQ:   w = '{1'b0, OP_SQ,   C_NEXT,        LIM_MAIN, P_WAIT};
      P_LOOP: w = '{1'b0, OP_ITER, C_HOLD_LOOP,   LIM_MAIN, P_AMUL};
      P_AMUL: w = '{1'b0, OP_AMUL, C_NEXT,        LIM_MAIN, P_WAIT};
      P_AFIN: w = '{1'b0, OP_AFIN, C_NEXT,        LIM_MAIN, P_WAIT};
      P_MODE: w = '{1'b0, OP_MODE, C_NEXT,        LIM_MAIN, P_WAIT};
      P_PROD: w = '{1'b0, OP_PROD, C_IF_NOT_SOFT, LIM_MAIN, P_EMIT};
      P_DIV:  w = '{1'b0, OP_DIV,  C_HOLD_LOOP,   LIM_DIV,  P_EMIT};
      P_EMIT: w = '{1'b0, OP_EMIT, C_HOLD_OUT,    LIM_MAIN, P_WAIT};
      default: w = '{1'b0, OP_NOP, C_GOTO,        LIM_MAIN, P_WAIT};
    endcase
    return w;
  endfunction

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [TAB_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/dsh_in_if.sv =====
// ----------------------------------------------------------------------------
// dsh_in_if: heading input channel
// Valid/ready channel carrying one heading vector word.
// ----------------------------------------------------------------------------
interface dsh_in_if import dsh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SPD_W-1:0] heading_x;
  logic signed [SPD_W-1:0] heading_y;

  modport source (output valid, heading_x, heading_y, input ready);
  modport sink   (input valid, heading_x, heading_y, output ready);
endinterface

// ===== rtl/dsh_out_if.sv =====
// ----------------------------------------------------------------------------
// dsh_out_if: wheel speed result channel
// Valid/ready channel carrying both wheel speeds and the turn mode.
// ----------------------------------------------------------------------------
interface dsh_out_if import dsh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SPD_W-1:0] left_speed;
  logic signed [SPD_W-1:0] right_speed;
  logic [MODE_W-1:0]       turn_mode;

  modport source (output valid, left_speed, right_speed, turn_mode, input ready);
  modport sink   (input valid, left_speed, right_speed, turn_mode, output ready);
endinterface

// ===== rtl/dsh_seq.sv =====
// ----------------------------------------------------------------------------
// dsh_seq: microcode sequencer
// Program counter over the step table, loop counter and branch decisions.
// ----------------------------------------------------------------------------
module dsh_seq import dsh_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output logic  in_ready,
  output ctrl_t ctrl
);

  localparam int LOOP_N = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int ITER_W = $clog2(LOOP_N);

  pc_t               pc_r, pc_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [ITER_W-1:0] lim;
  logic              loop_done;
  uword_t            w;

  // current control word
  assign w        = ucode(pc_r);
  assign in_ready = w.accept;
  assign ctrl.op   = w.op;
  assign ctrl.iter = TAB_IDX_W'(iter_r);

  // loop bound of this step
  always_comb begin
    unique case (w.lim)
      LIM_MAIN: lim = ITER_W'(LOOP_N - 1);
      LIM_DIV:  lim = ITER_W'(DIV_STEPS - 1);
    endcase
  end

  assign loop_done = (iter_r == lim);

  // next step and loop count
  always_comb begin
    pc_nxt   = pc_r + pc_t'(1);
    iter_nxt = '0;
    case (w.cond)
      C_NEXT:        pc_nxt = pc_r + pc_t'(1);
      C_GOTO:        pc_nxt = w.target;
      C_IF_NOT_SOFT: if (!stat.is_soft) begin
                       pc_nxt = w.target;
                     end
      C_HOLD_IN:     pc_nxt = in_valid ? w.target : pc_r;
      C_HOLD_LOOP:   if (loop_done) begin
                       pc_nxt = w.target;
                     end else begin
                       pc_nxt   = pc_r;
                       iter_nxt = iter_r + ITER_W'(1);
                     end
      C_HOLD_OUT:    pc_nxt = stat.out_free ? w.target : pc_r;
      default:       pc_nxt = P_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= P_WAIT;
      iter_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      iter_r <= iter_nxt;
    end
  end

endmodule

// ===== rtl/dsh_dp.sv =====
// ----------------------------------------------------------------------------
// dsh_dp: steering datapath
// Cordic vectoring, bit-serial root, turn mode update, restoring divider and
// the output register, each driven by the operation of the current step.
// ----------------------------------------------------------------------------
module dsh_dp import dsh_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_t                   ctrl,
  input  cfg_t                    cfg,
  input  logic signed [SPD_W-1:0] in_heading_x,
  input  logic signed [SPD_W-1:0] in_heading_y,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [SPD_W-1:0] out_left_speed,
  output logic signed [SPD_W-1:0] out_right_speed,
  output logic [MODE_W-1:0]       out_turn_mode,
  output stat_t                   stat
);

  localparam logic signed [Z_W-1:0]  Z_QUARTER = Z_W'(64'sd1 <<< 30);
  localparam logic signed [AP_W-1:0] RND_HALF  = AP_W'(64'sd1 <<< 31);
  localparam logic [SQ_W-1:0]        SQ_TOP    = SQ_W'(64'd1 << 30);

  // operand registers
  logic signed [SPD_W-1:0]     hx_r, hy_r;
  logic                        zero_r;
  logic signed [XY_W-1:0]      x_r, y_r;
  logic signed [Z_W-1:0]       z_r;
  logic [SQ_W-1:0]             sq_r, res_r, sqbit_r;
  logic signed [AP_W-1:0]      aprod_r;
  logic signed [SPD_W-1:0]     a_r;
  logic [ANGLE_W-1:0]          absa_r;
  logic [SPEED_W-1:0]          base_r;
  logic [ANGLE_W-1:0]          num_r;
  logic [ANGLE_W:0]            rem_r;
  logic [DIV_STEPS-1:0]        quo_r;
  logic [MODE_W-1:0]           mode_r, mode_nxt;
  logic                        out_valid_r;
  logic signed [SPD_W-1:0]     left_r, right_r;
  logic [MODE_W-1:0]           mode_out_r;

  // combinational helpers
  logic signed [SPD_W-1:0]     mop;
  logic signed [2*SPD_W-1:0]   msq;
  logic signed [XY_W-1:0]      xs, ys, dx, dy;
  logic signed [Z_W-1:0]       atan_v;
  logic [SQ_W-1:0]             sq_try;
  logic                        cordic_on, sqrt_on;
  logic signed [AP_W-1:0]      ang_rnd;
  logic signed [ANG_RAW_W-1:0] ang_raw;
  logic signed [SPD_W-1:0]     ang_clamp;
  logic [SPD_W-1:0]            len;
  logic [2*SPEED_W:0]          dvd;
  logic [ANGLE_W:0]            div_try;
  logic                        div_ge;
  logic signed [SPD_EXT_W-1:0] base_s, max_s, s1, s2;
  logic                        out_free, emit;

  function automatic logic signed [SPD_W-1:0] sat16(input logic signed [SPD_EXT_W-1:0] v);
    logic signed [SPD_W-1:0] r;
    if (v > SPD_EXT_W'(SPD_LIMIT)) begin
      r = SPD_W'(SPD_LIMIT);
    end else if (v < -SPD_EXT_W'(SPD_LIMIT)) begin
      r = -SPD_W'(SPD_LIMIT);
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

  // shared squaring multiplier
  assign mop = (ctrl.op == OP_SQ) ? hy_r : hx_r;
  assign msq = mop * mop;

  // heading scaled by 256, sign kept
  assign xs = XY_W'($signed({hx_r, 8'b0}));
  assign ys = XY_W'($signed({hy_r, 8'b0}));

  // cordic micro-rotation and root step enables
  assign cordic_on = {1'b0, ctrl.iter} < (TAB_IDX_W + 1)'(CORDIC_STEPS);
  assign sqrt_on   = {1'b0, ctrl.iter} < (TAB_IDX_W + 1)'(SQRT_STEPS);
  assign dx        = y_r >>> ctrl.iter;
  assign dy        = x_r >>> ctrl.iter;
  assign atan_v    = atan_lut(ctrl.iter);
  assign sq_try    = res_r + sqbit_r;

  // angle rounding and clamp to +-pi
  assign ang_rnd = aprod_r + RND_HALF;
  assign ang_raw = ang_rnd[AP_W-1:32];
  always_comb begin
    if (ang_raw > ANG_RAW_W'(PI_Q13)) begin
      ang_clamp = SPD_W'(PI_Q13);
    end else if (ang_raw < -ANG_RAW_W'(PI_Q13)) begin
      ang_clamp = -SPD_W'(PI_Q13);
    end else begin
      ang_clamp = ang_raw[SPD_W-1:0];
    end
  end

  // turn mode update, hard then soft then straight
  always_comb begin
    mode_nxt = (mode_r == MODE_RSVD) ? MODE_STRAIGHT : mode_r;
    if (mode_nxt == MODE_HARD && absa_r <= cfg.relax_thr) begin
      mode_nxt = MODE_SOFT;
    end
    if (mode_nxt == MODE_SOFT) begin
      if (absa_r > cfg.hard_thr) begin
        mode_nxt = MODE_HARD;
      end else if (absa_r <= cfg.straight) begin
        mode_nxt = MODE_STRAIGHT;
      end
    end
    if (mode_nxt == MODE_STRAIGHT) begin
      if (absa_r > cfg.hard_thr) begin
        mode_nxt = MODE_HARD;
      end else if (absa_r > cfg.straight) begin
        mode_nxt = MODE_SOFT;
      end
    end
  end

  // root result and soft-turn dividend
  assign len = res_r[SPD_W-1:0];
  assign dvd = base_r * num_r;

  // restoring divide step by hard turn angle
  assign div_try = {rem_r[ANGLE_W-1:0], quo_r[DIV_STEPS-1]};
  assign div_ge  = div_try >= {1'b0, cfg.hard_thr};

  // wheel speeds before saturation
  assign base_s = SPD_EXT_W'(base_r);
  assign max_s  = SPD_EXT_W'(cfg.speed_cap);
  always_comb begin
    unique case (mode_r)
      MODE_SOFT: begin
        s1 = (cfg.hard_thr == '0) ? '0 : SPD_EXT_W'(quo_r);
        s2 = (base_s <<< 1) - s1;
      end
      MODE_HARD: begin
        s1 = -max_s;
        s2 = max_s;
      end
      MODE_STRAIGHT, MODE_RSVD: begin
        s1 = base_s;
        s2 = base_s;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign emit     = (ctrl.op == OP_EMIT) && out_free;

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        hx_r <= in_heading_x;
        hy_r <= in_heading_y;
      end
      OP_PRE: begin
        zero_r  <= (hx_r == '0) && (hy_r == '0);
        sq_r    <= SQ_W'(msq);
        res_r   <= '0;
        sqbit_r <= SQ_TOP;
        if (hx_r < 0) begin
          if (hy_r >= 0) begin
            x_r <= ys;
            y_r <= -xs;
            z_r <= Z_QUARTER;
          end else begin
            x_r <= -ys;
            y_r <= xs;
            z_r <= -Z_QUARTER;
          end
        end else begin
          x_r <= xs;
          y_r <= ys;
          z_r <= '0;
        end
      end
      OP_SQ: begin
        sq_r <= sq_r + SQ_W'(msq);
      end
      OP_ITER: begin
        if (cordic_on) begin
          if (!y_r[XY_W-1]) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + atan_v;
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - atan_v;
          end
        end
        if (sqrt_on) begin
          if (sq_r >= sq_try) begin
            sq_r  <= sq_r - sq_try;
            res_r <= (res_r >> 1) + sqbit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          sqbit_r <= sqbit_r >> 2;
        end
      end
      OP_AMUL: begin
        aprod_r <= z_r * 17'(RAD_SCALE);
      end
      OP_AFIN: begin
        a_r    <= zero_r ? '0 : ang_clamp;
        absa_r <= zero_r ? '0 :
                  (ang_clamp < 0) ? ANGLE_W'(-ang_clamp) : ANGLE_W'(ang_clamp);
      end
      OP_MODE: begin
        base_r <= (len < SPD_W'(cfg.speed_cap)) ? SPEED_W'(len) : cfg.speed_cap;
        num_r  <= (cfg.hard_thr > absa_r) ? cfg.hard_thr - absa_r : '0;
      end
      OP_PROD: begin
        rem_r <= {1'b0, dvd[2*SPEED_W:DIV_STEPS]};
        quo_r <= dvd[DIV_STEPS-1:0];
      end
      OP_DIV: begin
        rem_r <= div_ge ? div_try - {1'b0, cfg.hard_thr} : div_try;
        quo_r <= {quo_r[DIV_STEPS-2:0], div_ge};
      end
      OP_EMIT: begin
        if (emit) begin
          left_r     <= (a_r > 0) ? sat16(s1) : sat16(s2);
          right_r    <= (a_r > 0) ? sat16(s2) : sat16(s1);
          mode_out_r <= mode_r;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // turn mode state and output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STRAIGHT;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.op == OP_MODE) begin
        mode_r <= mode_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_speed  = left_r;
  assign out_right_speed = right_r;
  assign out_turn_mode   = mode_out_r;
  assign stat.is_soft    = (mode_r == MODE_SOFT);
  assign stat.out_free   = out_free;

endmodule

// ===== rtl/differential_steering_hysteresis_unit.sv =====
// ----------------------------------------------------------------------------
// differential_steering_hysteresis_unit: heading to wheel speeds
// Heading angle and length, hysteretic turn mode and differential wheel speeds,
// run as a short microcoded program over one shared datapath.
// ----------------------------------------------------------------------------
// the cordic rotation and the root run in one shared loop; soft turns add the 14-step
//   restoring divider before the output word is written
// one heading is taken at a time; the next is accepted only after the last word is emitted
// a finished word waits in the output register while the next heading is taken
// reset: synchronous, active low; turn mode to straight, configuration to defaults, out valid low
module differential_steering_hysteresis_unit import dsh_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dsh_in_if.sink               in_if,
  dsh_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t  cfg_r;
  ctrl_t ctrl;
  stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hard_thr  <= ANGLE_W'(12868);
      cfg_r.relax_thr <= ANGLE_W'(10008);
      cfg_r.straight  <= ANGLE_W'(1430);
      cfg_r.speed_cap <= SPEED_W'(2560);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HARD_THR:  cfg_r.hard_thr  <= cfg_wdata[ANGLE_W-1:0];
        REG_RELAX_THR: cfg_r.relax_thr <= cfg_wdata[ANGLE_W-1:0];
        REG_STRAIGHT:  cfg_r.straight  <= cfg_wdata[ANGLE_W-1:0];
        REG_SPEED_CAP: cfg_r.speed_cap <= cfg_wdata[SPEED_W-1:0];
      endcase
    end
  end

  // step sequencer
  dsh_seq #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .stat     (stat),
    .in_ready (in_if.ready),
    .ctrl     (ctrl)
  );

  // datapath and output register
  dsh_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .cfg             (cfg_r),
    .in_heading_x    (in_if.heading_x),
    .in_heading_y    (in_if.heading_y),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_left_speed  (out_if.left_speed),
    .out_right_speed (out_if.right_speed),
    .out_turn_mode   (out_if.turn_mode),
    .stat            (stat)
  );

endmodule

// ===== rtl/dsh_checker.sv =====
// ----------------------------------------------------------------------------
// dsh_checker: port-level checks for the steering unit
// Watches both channels and the wheel speed relations of each turn mode.
// ----------------------------------------------------------------------------
module dsh_checker import dsh_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SPD_W-1:0] left_speed,
  input logic signed [SPD_W-1:0] right_speed,
  input logic [MODE_W-1:0]       turn_mode
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_speed) &&
                                $stable(right_speed) && $stable(turn_mode))
    else $error("result word changed while stalled");

  // one heading at a time: ready drops after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second heading taken while one is in work");

  // straight drives both wheels alike
  a_straight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && turn_mode == MODE_STRAIGHT |-> left_speed == right_speed)
    else $error("straight mode with unequal wheel speeds");

  // hard turn spins in place
  a_hard: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && turn_mode == MODE_HARD |-> left_speed == -right_speed)
    else $error("hard turn wheels not opposite");

  // soft turn never reverses a wheel
  a_soft: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && turn_mode == MODE_SOFT |-> left_speed >= 0 && right_speed >= 0)
    else $error("soft turn with a reversed wheel");

endmodule

bind differential_steering_hysteresis_unit dsh_checker u_dsh_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .left_speed  (out_if.left_speed),
  .right_speed (out_if.right_speed),
  .turn_mode   (out_if.turn_mode)
);
